@@ hw/rtl/trade_volume_time_window_assert.svh @@
// Assertion macros for the trade volume time window block.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef TRADE_VOLUME_TIME_WINDOW_ASSERT_SVH
`define TRADE_VOLUME_TIME_WINDOW_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define TVTW_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset
`define TVTW_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/tvtw_pkg.sv @@
// Shared types, constants and helpers for the trade volume time window block.
// No dependencies; the interfaces, divider, datapath, controller and top module import this package.
package tvtw_pkg;

  // Store geometry
  localparam int STORE_DEPTH = 1024;
  localparam int PTR_BITS    = $clog2(STORE_DEPTH);
  localparam int COUNT_BITS  = $clog2(STORE_DEPTH + 1);

  // Field widths
  localparam int TIME_BITS  = 32;
  localparam int SIZE_BITS  = 24;
  localparam int SUM_BITS   = 34;
  localparam int SPAN_BITS  = 16;
  localparam int PCT_BITS   = 15;
  localparam int SPLIT_BITS = SUM_BITS + 1;
  localparam int PROD_BITS  = SUM_BITS + PCT_BITS;
  localparam int DIV_CNT_BITS = $clog2(PCT_BITS + 1);

  // Percent scale: 100 with 8 fraction bits
  localparam int PCT_SCALE = 25600;
  localparam logic [SPAN_BITS-1:0] SPAN_RESET = SPAN_BITS'(60);

  // Command codes
  localparam logic CMD_ADD    = 1'b0;
  localparam logic CMD_EXPIRE = 1'b1;

  typedef struct packed {
    logic                 command;
    logic [TIME_BITS-1:0] time_sec;
    logic [SIZE_BITS-1:0] trade_size;
    logic                 counts_in_split;
    logic                 is_sell;
  } item_t;

  typedef struct packed {
    logic [COUNT_BITS-1:0] trade_count;
    logic [SUM_BITS-1:0]   total_volume;
    logic [SUM_BITS-1:0]   buy_volume;
    logic [SUM_BITS-1:0]   sell_volume;
    logic [PCT_BITS-1:0]   buy_percent;
    logic                  percent_valid;
    logic                  rejected_full;
  } result_t;

  // One stored trade
  typedef struct packed {
    logic [TIME_BITS-1:0] stamp;
    logic [SIZE_BITS-1:0] size;
    logic                 counted;
    logic                 sell;
  } trade_rec_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic add_commit;
    logic expire_pop;
    logic pct_start;
    logic out_load;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic store_empty;
    logic oldest_expired;
    logic div_done;
    logic out_free;
  } dp_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_EXP_RD,
    ST_EXP_CHK,
    ST_PCT,
    ST_DIV,
    ST_DONE
  } tvtw_state_t;

  // Circular pointer advance
  function automatic logic [PTR_BITS-1:0] next_slot(input logic [PTR_BITS-1:0] ptr);
    next_slot = (ptr == PTR_BITS'(STORE_DEPTH - 1)) ? '0 : ptr + 1'b1;
  endfunction

endpackage

@@ hw/rtl/tvtw_item_if.sv @@
// Input channel interface: valid/ready handshake with an item_t payload.
// Depends on tvtw_pkg.
interface tvtw_item_if;
  import tvtw_pkg::*;

  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/tvtw_result_if.sv @@
// Result channel interface: valid/ready handshake with a result_t payload.
// Depends on tvtw_pkg.
interface tvtw_result_if;
  import tvtw_pkg::*;

  logic    valid;
  logic    ready;
  result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/tvtw_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies; contents are undefined until written.
module tvtw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ hw/rtl/tvtw_div.sv @@
// Restoring divider for the buy percentage, one quotient bit per cycle.
// Depends on tvtw_pkg. Quotient is known to fit PCT_BITS bits.
module tvtw_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [tvtw_pkg::PROD_BITS-1:0] dividend,
  input  logic [tvtw_pkg::SPLIT_BITS-1:0] divisor,
  output logic                           done,
  output logic [tvtw_pkg::PCT_BITS-1:0]  quotient,
  output logic                           nonzero
);
  import tvtw_pkg::*;

  logic [DIV_CNT_BITS-1:0] cnt;
  logic [SPLIT_BITS-1:0]   rem;
  logic [SPLIT_BITS-1:0]   den;
  logic [PCT_BITS-1:0]     shreg;   // low dividend bits in, quotient bits out
  logic [SPLIT_BITS:0]     trial;
  logic [SPLIT_BITS:0]     diff;
  logic                    qbit;

  // One restoring step
  always_comb begin
    trial = {rem, shreg[PCT_BITS-1]};
    diff  = trial - {1'b0, den};
    qbit  = (trial >= {1'b0, den});
  end

  // Step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= (divisor == '0) ? '0 : DIV_CNT_BITS'(PCT_BITS);
    end else if (cnt != '0) begin
      cnt <= cnt - 1'b1;
    end
  end

  // Remainder and quotient registers; upper dividend bits seed the remainder
  always_ff @(posedge clk) begin
    if (start) begin
      den     <= divisor;
      nonzero <= (divisor != '0);
      if (divisor == '0) begin
        rem   <= '0;
        shreg <= '0;
      end else begin
        rem   <= {1'b0, dividend[PROD_BITS-1:PCT_BITS]};
        shreg <= dividend[PCT_BITS-1:0];
      end
    end else if (cnt != '0) begin
      rem   <= qbit ? diff[SPLIT_BITS-1:0] : trial[SPLIT_BITS-1:0];
      shreg <= {shreg[PCT_BITS-2:0], qbit};
    end
  end

  assign done     = (cnt == '0);
  assign quotient = shreg;

endmodule

@@ hw/rtl/tvtw_dp.sv @@
// Datapath: item register, trade store, pointers, running sums, span register,
// percentage divider and result register. Depends on tvtw_pkg, tvtw_ram,
// tvtw_div and tvtw_result_if.
module tvtw_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [tvtw_pkg::SPAN_BITS-1:0]  cfg_wdata,
  input  tvtw_pkg::item_t                 item_data,
  input  tvtw_pkg::ctrl_cmd_t             cmd,
  output tvtw_pkg::dp_stat_t              stat,
  tvtw_result_if.source                   result
);
  import tvtw_pkg::*;

  item_t                 item_q;
  logic                  rejected_q;
  logic [SPAN_BITS-1:0]  span;
  logic [PTR_BITS-1:0]   oldest;
  logic [PTR_BITS-1:0]   newest;
  logic [COUNT_BITS-1:0] count;
  logic [SUM_BITS-1:0]   total_sum;
  logic [SUM_BITS-1:0]   buy_sum;
  logic [SUM_BITS-1:0]   sell_sum;

  trade_rec_t            wr_rec;
  trade_rec_t            rd_rec;
  logic                  store_we;
  logic                  full;
  logic [SUM_BITS-1:0]   add_size;
  logic [SUM_BITS-1:0]   pop_size;
  logic [SPLIT_BITS-1:0] split;
  logic [PROD_BITS-1:0]  product;
  logic                  div_done;
  logic [PCT_BITS-1:0]   quotient;
  logic                  pct_nonzero;

  assign full     = (count == COUNT_BITS'(STORE_DEPTH));
  assign store_we = cmd.add_commit && !full;
  assign add_size = SUM_BITS'(item_q.trade_size);
  assign pop_size = SUM_BITS'(rd_rec.size);

  // New trade record
  always_comb begin
    wr_rec.stamp   = item_q.time_sec;
    wr_rec.size    = item_q.trade_size;
    wr_rec.counted = item_q.counts_in_split;
    wr_rec.sell    = item_q.is_sell;
  end

  // Trade store, always reading the oldest slot
  tvtw_ram #(
    .WIDTH ($bits(trade_rec_t)),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .we      (store_we),
    .wr_addr (newest),
    .wr_data (wr_rec),
    .rd_addr (oldest),
    .rd_data (rd_rec)
  );

  // Item and reject flag capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_q     <= item_data;
      rejected_q <= 1'b0;
    end else if (cmd.add_commit && full) begin
      rejected_q <= 1'b1;
    end
  end

  // Span register, pointers, count and sums
  always_ff @(posedge clk) begin
    if (rst) begin
      span      <= SPAN_RESET;
      oldest    <= '0;
      newest    <= '0;
      count     <= '0;
      total_sum <= '0;
      buy_sum   <= '0;
      sell_sum  <= '0;
    end else begin
      if (cfg_we) begin
        span <= cfg_wdata;
      end
      if (store_we) begin
        newest    <= next_slot(newest);
        count     <= count + 1'b1;
        total_sum <= total_sum + add_size;
        if (item_q.counts_in_split && item_q.is_sell) begin
          sell_sum <= sell_sum + add_size;
        end
        if (item_q.counts_in_split && !item_q.is_sell) begin
          buy_sum <= buy_sum + add_size;
        end
      end else if (cmd.expire_pop) begin
        oldest    <= next_slot(oldest);
        count     <= count - 1'b1;
        total_sum <= total_sum - pop_size;
        if (rd_rec.counted && rd_rec.sell) begin
          sell_sum <= sell_sum - pop_size;
        end
        if (rd_rec.counted && !rd_rec.sell) begin
          buy_sum <= buy_sum - pop_size;
        end
      end
    end
  end

  // Percentage operands; the divider registers them at start
  assign split   = {1'b0, buy_sum} + {1'b0, sell_sum};
  assign product = PROD_BITS'(buy_sum) * PROD_BITS'(PCT_SCALE);

  tvtw_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.pct_start),
    .dividend (product),
    .divisor  (split),
    .done     (div_done),
    .quotient (quotient),
    .nonzero  (pct_nonzero)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (cmd.out_load) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result.data.trade_count   <= count;
      result.data.total_volume  <= total_sum;
      result.data.buy_volume    <= buy_sum;
      result.data.sell_volume   <= sell_sum;
      result.data.buy_percent   <= quotient;
      result.data.percent_valid <= pct_nonzero;
      result.data.rejected_full <= rejected_q;
    end
  end

  // Status to controller; expiry when now exceeds stamp plus span
  always_comb begin
    stat.store_empty    = (count == '0);
    stat.oldest_expired = ({1'b0, item_q.time_sec} >
                           ({1'b0, rd_rec.stamp} + (TIME_BITS + 1)'(span)));
    stat.div_done       = div_done;
    stat.out_free       = !result.valid || result.ready;
  end

endmodule

@@ hw/rtl/tvtw_ctrl.sv @@
// Controller state machine: sequences add, expiry walk, division and result load.
// Depends on tvtw_pkg.
module tvtw_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_command,
  output logic                 in_ready,
  input  tvtw_pkg::dp_stat_t   stat,
  output tvtw_pkg::ctrl_cmd_t  cmd
);
  import tvtw_pkg::*;

  tvtw_state_t state;
  tvtw_state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = (in_command == CMD_EXPIRE) ? ST_EXP_RD : ST_ADD;
        end
      end
      ST_ADD: begin
        cmd.add_commit = 1'b1;
        state_next     = ST_PCT;
      end
      // wait here while the oldest record comes out of the store's registered read port
      ST_EXP_RD: begin
        state_next = stat.store_empty ? ST_PCT : ST_EXP_CHK;
      end
      ST_EXP_CHK: begin
        if (stat.oldest_expired) begin
          cmd.expire_pop = 1'b1;
          state_next     = ST_EXP_RD;
        end else begin
          state_next = ST_PCT;
        end
      end
      ST_PCT: begin
        cmd.pct_start = 1'b1;
        state_next    = ST_DIV;
      end
      ST_DIV: begin
        if (stat.div_done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ hw/rtl/trade_volume_time_window.sv @@
// Trade volume time window: handles one add or expire transaction at a time and
// takes the next one only after the result of the last is loaded for output.
// Expire removes trades from the oldest while they have expired; when buy plus
// sell is zero the divider steps are skipped.
// Rate is set by the 15-step serial percentage divider and the expiry walk.
// Synchronous reset clears count, pointers, sums and sets the span to 60;
// the trade store is not cleared, so no clearing pass is needed.
`include "trade_volume_time_window_assert.svh"

module trade_volume_time_window (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [tvtw_pkg::SPAN_BITS-1:0] cfg_wdata,
  tvtw_item_if.sink                      item,
  tvtw_result_if.source                  result
);
  import tvtw_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // Sequencer
  tvtw_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (item.valid),
    .in_command (item.data.command),
    .in_ready   (item.ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // Store, sums and result register
  tvtw_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .item_data (item.data),
    .cmd       (cmd),
    .stat      (stat),
    .result    (result)
  );

  // Checks
  `TVTW_ASSERT_IMP(a_load_free, cmd.out_load, stat.out_free, "result overwritten while held")
  `TVTW_ASSERT_IMP(a_pop_nonempty, cmd.expire_pop, !stat.store_empty, "expiry pop on empty store")
  `TVTW_ASSERT_NXT(a_one_at_a_time, item.valid && item.ready, !item.ready, "second transaction accepted while busy")

endmodule

@@ tb/tb_trade_volume_time_window.sv @@
// Testbench for trade_volume_time_window: sends add and expire transactions and
// checks every report field against a window model kept inside this file.
// Depends on tvtw_pkg, tvtw_item_if, tvtw_result_if and the block itself.
module tb_trade_volume_time_window;
  import tvtw_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int IDLE_GAP    = 30;   // settle cycles before a span write
  localparam int END_SETTLE  = 60;
  localparam int PHASE_ITEMS = 90;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [SPAN_BITS-1:0] cfg_wdata;

  tvtw_item_if   item_ch();
  tvtw_result_if result_ch();

  trade_volume_time_window u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .item     (item_ch),
    .result   (result_ch)
  );

  // Window model: circular trade store, pointers, count and running sums
  trade_rec_t           win_store [STORE_DEPTH];
  logic [PTR_BITS-1:0]  win_oldest;
  logic [PTR_BITS-1:0]  win_newest;
  int unsigned          win_count;
  logic [SUM_BITS-1:0]  win_total;
  logic [SUM_BITS-1:0]  win_buy;
  logic [SUM_BITS-1:0]  win_sell;
  logic [SPAN_BITS-1:0] win_span;

  result_t              expected_reports[$];
  int unsigned          mismatch_count;
  int unsigned          send_idle_pct;
  int unsigned          recv_stall_pct;
  int unsigned          hold_req;
  int unsigned          hold_left;
  int unsigned          cycle_count;
  logic [TIME_BITS-1:0] stream_sec;   // timestamp of the well-formed trade stream

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Add or remove one trade from the sums
  function automatic void account_trade(input trade_rec_t t, input logic adding);
    logic [SUM_BITS-1:0] amt;
    amt = SUM_BITS'(t.size);
    win_total = adding ? win_total + amt : win_total - amt;
    if (t.counted) begin
      if (t.sell) win_sell = adding ? win_sell + amt : win_sell - amt;
      else win_buy = adding ? win_buy + amt : win_buy - amt;
    end
  endfunction

  // Apply one transaction to the window model and build its report
  function automatic result_t window_step(input item_t it);
    result_t             rep;
    trade_rec_t          t;
    logic [TIME_BITS+1:0] keep_until;
    logic [SUM_BITS:0]   split;
    logic [63:0]         scaled;
    rep = '0;
    if (it.command == CMD_ADD) begin
      if (win_count == STORE_DEPTH) begin
        rep.rejected_full = 1'b1;
      end else begin
        t.stamp   = it.time_sec;
        t.size    = it.trade_size;
        t.counted = it.counts_in_split;
        t.sell    = it.is_sell;
        win_store[win_newest] = t;
        account_trade(t, 1'b1);
        win_newest = next_slot(win_newest);
        win_count++;
      end
    end else begin
      // oldest first; stop at the first trade still inside the span
      while (win_count > 0) begin
        keep_until = {2'b00, win_store[win_oldest].stamp} + win_span;
        if ({2'b00, it.time_sec} <= keep_until) break;
        account_trade(win_store[win_oldest], 1'b0);
        win_oldest = next_slot(win_oldest);
        win_count--;
      end
    end
    split = {1'b0, win_buy} + win_sell;
    rep.trade_count  = COUNT_BITS'(win_count);
    rep.total_volume = win_total;
    rep.buy_volume   = win_buy;
    rep.sell_volume  = win_sell;
    if (split != 0) begin
      scaled = 64'(win_buy) * 64'(PCT_SCALE);
      rep.buy_percent   = PCT_BITS'(scaled / 64'(split));
      rep.percent_valid = 1'b1;
    end
    return rep;
  endfunction

  function automatic item_t make_item(input logic cmd, input logic [TIME_BITS-1:0] sec,
                                      input logic [SIZE_BITS-1:0] size,
                                      input logic counted, input logic sell);
    item_t it;
    it.command         = cmd;
    it.time_sec        = sec;
    it.trade_size      = size;
    it.counts_in_split = counted;
    it.is_sell         = sell;
    return it;
  endfunction

  function automatic logic [SIZE_BITS-1:0] pick_size();
    case ($urandom_range(3, 0))
      0: pick_size = SIZE_BITS'($urandom_range(255, 0));
      1: pick_size = $urandom_range(1, 0) ? '1 : '0;
      default: pick_size = SIZE_BITS'($urandom);
    endcase
  endfunction

  function automatic void check_field(input string field_name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s expected %0d got %0d", $time, field_name, want, got);
    end
  endfunction

  // Send one transaction; called and returns at a falling edge
  task automatic send_item(input item_t it);
    logic [$bits(item_t)-1:0] junk;
    while ($urandom_range(99, 0) < send_idle_pct) begin
      junk = $bits(item_t)'({$urandom, $urandom});
      item_ch.valid <= 1'b0;
      item_ch.data  <= junk;
      @(negedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.data  <= it;
    do @(posedge clk); while (item_ch.ready !== 1'b1);
    expected_reports.push_back(window_step(it));
    @(negedge clk);
  endtask

  // Stop offering and wait for every outstanding report
  task automatic wait_reports_done();
    item_ch.valid <= 1'b0;
    while (expected_reports.size() != 0) @(negedge clk);
  endtask

  task automatic write_span(input logic [SPAN_BITS-1:0] span);
    wait_reports_done();
    repeat (IDLE_GAP) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= span;
    @(negedge clk);
    cfg_we   <= 1'b0;
    win_span = span;
  endtask

  // Mostly time-ordered adds and expires, with some noise
  task automatic send_stream_item();
    item_t       it;
    int unsigned step;
    int unsigned roll;
    step = 32'(win_span) / 8 + 2;
    roll = $urandom_range(99, 0);
    it = make_item(CMD_ADD, stream_sec, pick_size(), 1'($urandom_range(1, 0)),
                   1'($urandom_range(1, 0)));
    if (roll < 10) begin
      it.command    = $urandom_range(1, 0) ? CMD_EXPIRE : CMD_ADD;
      it.trade_size = SIZE_BITS'($urandom);
      if (it.command == CMD_EXPIRE) it.time_sec = $urandom;
      else it.time_sec = stream_sec + $urandom_range(win_span, 0) - $urandom_range(win_span, 0);
    end else if (roll < 75) begin
      stream_sec += $urandom_range(step, 0);
    end else begin
      it.command  = CMD_EXPIRE;
      it.time_sec = stream_sec + $urandom_range(win_span / 2 + 1, 0);
    end
    send_item(it);
  endtask

  // Default span of 60, empty split, sell-only and buy-only shares
  task automatic test_default_span_window();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_item(make_item(CMD_EXPIRE, '0, '0, 1'b0, 1'b0));
    send_item(make_item(CMD_ADD, 32'd1000, '0, 1'b1, 1'b0));   // counted but zero size
    send_item(make_item(CMD_ADD, 32'd1000, '1, 1'b0, 1'b1));   // largest size, not counted
    send_item(make_item(CMD_ADD, 32'd1010, 24'd1000, 1'b1, 1'b1));
    send_item(make_item(CMD_ADD, 32'd1020, 24'd3000, 1'b1, 1'b0));
    send_item(make_item(CMD_EXPIRE, 32'd1060, '1, 1'b1, 1'b1)); // age equal to span stays
    send_item(make_item(CMD_EXPIRE, 32'd1061, '0, 1'b0, 1'b0));
    send_item(make_item(CMD_EXPIRE, 32'd1080, '1, 1'b0, 1'b1)); // only buy left
  endtask

  // Future and out-of-order stamps, 32-bit overflow of stamp plus span, span extremes
  task automatic test_timestamp_edges();
    send_item(make_item(CMD_ADD, 32'd5000, 24'd7, 1'b0, 1'b0));
    send_item(make_item(CMD_EXPIRE, 32'd1082, '0, 1'b0, 1'b0)); // stops at the future stamp
    send_item(make_item(CMD_ADD, 32'd2000, 24'd9, 1'b1, 1'b1));
    send_item(make_item(CMD_EXPIRE, 32'd3000, '0, 1'b0, 1'b0)); // stale trade behind a live one
    send_item(make_item(CMD_EXPIRE, '1, '0, 1'b0, 1'b0));
    send_item(make_item(CMD_ADD, 32'hFFFF_FFF0, '1, 1'b1, 1'b1));
    send_item(make_item(CMD_EXPIRE, '1, '0, 1'b0, 1'b0));       // limit passes 2^32, kept
    write_span('0);
    send_item(make_item(CMD_EXPIRE, 32'hFFFF_FFF0, '0, 1'b0, 1'b0));
    send_item(make_item(CMD_EXPIRE, 32'hFFFF_FFF1, '0, 1'b0, 1'b0));
    write_span('1);
    send_item(make_item(CMD_ADD, 32'd100, 24'd5, 1'b1, 1'b0));
    send_item(make_item(CMD_EXPIRE, 32'd65635, '0, 1'b0, 1'b0));
    send_item(make_item(CMD_EXPIRE, 32'd65636, '0, 1'b0, 1'b0));
  endtask

  // Random stream under each idling pattern, two spans per pattern
  task automatic test_random_traffic();
    int unsigned          idle_set  [4] = '{0, 70, 0, 38};
    int unsigned          stall_set [4] = '{0, 0, 70, 38};
    logic [SPAN_BITS-1:0] fixed_span[4] = '{16'd60, 16'd0, 16'hFFFF, 16'd1};
    stream_sec = $urandom_range(32'h4000_0000, 32'h0010_0000);
    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = idle_set[p];
      recv_stall_pct = stall_set[p];
      for (int h = 0; h < 2; h++) begin
        write_span(h == 0 ? fixed_span[p] : SPAN_BITS'($urandom_range(2000, 1)));
        repeat (PHASE_ITEMS) send_stream_item();
      end
    end
  endtask

  // Long result stall while transactions keep coming, then a full drain
  task automatic test_input_stall();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = 400;
    repeat (8) send_stream_item();
    wait_reports_done();
  endtask

  // Fill the store, get adds refused, then expire in bulk
  task automatic test_store_full();
    logic [TIME_BITS-1:0] first_sec;
    logic [TIME_BITS-1:0] sec;
    send_idle_pct  = 38;
    recv_stall_pct = 38;
    write_span('0);
    send_item(make_item(CMD_EXPIRE, '1, '0, 1'b0, 1'b0));
    first_sec = $urandom_range(32'h8000_0000, 32'h0100_0000);
    sec       = first_sec;
    while (win_count < STORE_DEPTH) begin
      send_item(make_item(CMD_ADD, sec, pick_size(), 1'($urandom_range(1, 0)),
                          1'($urandom_range(1, 0))));
      sec += $urandom_range(2, 0);
    end
    repeat (3) send_item(make_item(CMD_ADD, $urandom, pick_size(),
                                   1'($urandom_range(1, 0)), 1'($urandom_range(1, 0))));
    send_item(make_item(CMD_EXPIRE, first_sec - 1, '0, 1'b0, 1'b0));
    send_item(make_item(CMD_ADD, sec, '1, 1'b1, 1'b0));
    write_span(16'd100);
    send_item(make_item(CMD_EXPIRE, first_sec + 600, '0, 1'b0, 1'b0));
    send_item(make_item(CMD_ADD, sec, pick_size(), 1'b1, 1'b1));
    write_span('1);
    send_item(make_item(CMD_EXPIRE, '1, '0, 1'b0, 1'b0));
  endtask

  // Result side: random stalls plus requested long holds
  initial begin : result_sink
    result_ch.ready = 1'b0;
    hold_left       = 0;
    forever begin
      @(negedge clk);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
      end
    end
  end

  // Compare each accepted report with the oldest expected one
  always @(posedge clk) begin : report_check
    result_t want;
    if (!rst && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
      if (expected_reports.size() == 0) begin
        mismatch_count++;
        $display("%0t: report expected none got %p", $time, result_ch.data);
      end else begin
        want = expected_reports.pop_front();
        check_field("trade_count", 64'(want.trade_count), 64'(result_ch.data.trade_count));
        check_field("total_volume", 64'(want.total_volume),
                    64'(result_ch.data.total_volume));
        check_field("buy_volume", 64'(want.buy_volume), 64'(result_ch.data.buy_volume));
        check_field("sell_volume", 64'(want.sell_volume), 64'(result_ch.data.sell_volume));
        check_field("buy_percent", 64'(want.buy_percent), 64'(result_ch.data.buy_percent));
        check_field("percent_valid", 64'(want.percent_valid),
                    64'(result_ch.data.percent_valid));
        check_field("rejected_full", 64'(want.rejected_full),
                    64'(result_ch.data.rejected_full));
      end
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin : main_sequence
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    item_ch.valid  = 1'b0;
    item_ch.data   = '0;
    mismatch_count = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = 0;
    win_oldest     = '0;
    win_newest     = '0;
    win_count      = 0;
    win_total      = '0;
    win_buy        = '0;
    win_sell       = '0;
    win_span       = SPAN_RESET;
    stream_sec     = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_default_span_window();
    test_timestamp_edges();
    test_random_traffic();
    test_input_stall();
    test_store_full();

    wait_reports_done();
    repeat (END_SETTLE) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
